// ===== hw/rtl/brld_pkg.sv =====
// shared types and constants for the byte run-length decoder
package brld_pkg;

  localparam logic [7:0] CODE_SPLIT  = 8'h80;
  localparam int         QUEUE_DEPTH = 4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_SHORT   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte_0;
    logic [7:0] out_byte_1;
    logic [7:0] out_byte_2;
    logic [7:0] out_byte_3;
    logic [2:0] byte_count;
    logic [1:0] error_code;
    logic       image_done;
    logic       run_last;
  } out_item_t;

  // work handed from the front end to the back end
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    logic [1:0] err;
    logic       done;
  } cmd_t;

endpackage

// ===== hw/rtl/byte_run_length_decoder_unit.sv =====
// top level of the byte run-length decoder
// path: the first word of a result is registered in the command queue, in the back-end work
// register and in the output register after the input byte that causes it is taken
// throughput: one input byte per cycle for literals and codes while the command queue has room;
// a repeat of n bytes becomes ceil(n / lanes) output words, one output word per cycle while
// out_ready is high, and the four-entry command queue fills before input stalls
// reset: synchronous, clears queue and output, image_size returns to 1
module byte_run_length_decoder_unit #(
  parameter int SIZE_BITS = 24,
  parameter int OUT_LANES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  brld_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output brld_pkg::out_item_t out_item
);

  localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);

  logic           push;
  logic           push_ready;
  brld_pkg::cmd_t push_cmd;
  logic           q_valid;
  logic           q_pop;
  brld_pkg::cmd_t q_cmd;

  brld_front #(.SIZE_BITS(SIZE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (push),
    .cmd_ready (push_ready),
    .cmd       (push_cmd)
  );

  brld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  brld_back #(.OUT_LANES(OUT_LANES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_count_in_lanes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.byte_count <= 3'(LANES))
    else $error("byte_count exceeds lane count");

  a_err_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error_code != brld_pkg::ERR_NONE |->
      out_item.run_last && out_item.image_done)
    else $error("error flagged on a word that is not the final one");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.image_done |-> out_item.run_last)
    else $error("image_done set on a word that is not the final one");

  a_status_has_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.byte_count == 3'd0 |-> out_item.image_done)
    else $error("empty word without image_done");
`endif

endmodule

// ===== hw/rtl/brld_front.sv =====
// front end: parses code bytes, tracks image size, issues output commands
module brld_front #(
  parameter int SIZE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  brld_pkg::in_item_t in_item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output brld_pkg::cmd_t     cmd
);

  localparam logic [1:0] PH_CODE    = 2'd0;
  localparam logic [1:0] PH_REPEAT  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;
  localparam logic [1:0] PH_DRAIN   = 2'd3;

  logic [23:0]          image_size;
  logic [1:0]           phase;
  logic [1:0]           phase_next;
  logic [7:0]           run_left;
  logic [7:0]           run_left_next;
  logic [SIZE_BITS-1:0] bytes_remaining;
  logic [SIZE_BITS-1:0] bytes_remaining_next;
  logic [SIZE_BITS-1:0] reload;
  logic [SIZE_BITS-1:0] cfg_reload;
  logic [31:0]          size_ext;
  logic [31:0]          cfg_ext;
  logic [7:0]           put;
  logic                 is_repeat;
  logic                 push;
  logic                 accepted;

  assign size_ext   = {8'd0, image_size};
  assign cfg_ext    = {8'd0, cfg_wdata};
  assign reload     = size_ext[SIZE_BITS-1:0];
  assign cfg_reload = cfg_ext[SIZE_BITS-1:0];

  assign in_ready  = cmd_ready;
  assign accepted  = in_valid && in_ready;
  assign cmd_valid = accepted && push;

  assign is_repeat = in_item.data_byte > brld_pkg::CODE_SPLIT;
  assign put = is_repeat ? (in_item.data_byte - 8'd127) : (in_item.data_byte + 8'd1);

  always_comb begin
    phase_next           = phase;
    run_left_next        = run_left;
    bytes_remaining_next = bytes_remaining;
    push                 = 1'b0;
    cmd.value            = in_item.data_byte;
    cmd.count            = 8'd0;
    cmd.err              = brld_pkg::ERR_NONE;
    cmd.done             = 1'b0;
    unique case (phase)
      PH_CODE: begin
        if (SIZE_BITS'(put) > bytes_remaining) begin
          push       = 1'b1;
          cmd.err    = brld_pkg::ERR_OVERRUN;
          cmd.done   = 1'b1;
          phase_next = PH_DRAIN;
        end else begin
          run_left_next = put;
          phase_next    = is_repeat ? PH_REPEAT : PH_LITERAL;
        end
      end
      PH_REPEAT: begin
        push                 = 1'b1;
        cmd.count            = run_left;
        bytes_remaining_next = bytes_remaining - SIZE_BITS'(run_left);
        run_left_next        = 8'd0;
        if (bytes_remaining_next == '0) begin
          cmd.done   = 1'b1;
          phase_next = PH_DRAIN;
        end else begin
          phase_next = PH_CODE;
        end
      end
      PH_LITERAL: begin
        push                 = 1'b1;
        cmd.count            = 8'd1;
        bytes_remaining_next = bytes_remaining - SIZE_BITS'(1);
        run_left_next        = run_left - 8'd1;
        if (run_left_next == 8'd0) phase_next = PH_CODE;
        if (bytes_remaining_next == '0) begin
          cmd.done      = 1'b1;
          run_left_next = 8'd0;
          phase_next    = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        push = 1'b0;
      end
    endcase
    if (in_item.end_of_input) begin
      // input ended with the image still open
      if (phase_next != PH_DRAIN) begin
        push     = 1'b1;
        cmd.err  = brld_pkg::ERR_SHORT;
        cmd.done = 1'b1;
      end
      phase_next           = PH_CODE;
      run_left_next        = 8'd0;
      bytes_remaining_next = reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size      <= 24'd1;
      phase           <= PH_CODE;
      run_left        <= 8'd0;
      bytes_remaining <= SIZE_BITS'(1);
    end else if (cfg_we) begin
      image_size      <= cfg_wdata;
      phase           <= PH_CODE;
      run_left        <= 8'd0;
      bytes_remaining <= cfg_reload;
    end else if (accepted) begin
      phase           <= phase_next;
      run_left        <= run_left_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ===== hw/rtl/brld_queue.sv =====
// small command queue between front end and back end
module brld_queue #(
  parameter int DEPTH = brld_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  brld_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output brld_pkg::cmd_t pop_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  brld_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/brld_back.sv =====
// back end: expands commands into output words with a registered output
module brld_back #(
  parameter int OUT_LANES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  brld_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output brld_pkg::out_item_t out_item
);

  localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);

  logic           work_valid;
  brld_pkg::cmd_t work;
  logic [7:0]     left;
  logic [2:0]     lane_cnt;
  logic           last;
  logic           emit;
  logic [7:0]     lane_byte [4];
  brld_pkg::out_item_t word;

  assign lane_cnt = (left < 8'(LANES)) ? left[2:0] : 3'(LANES);
  assign last     = left <= 8'(LANES);
  assign emit     = work_valid && (!out_valid || out_ready);
  assign cmd_pop  = cmd_valid && (!work_valid || (emit && last));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_byte[i] = (3'(i) < lane_cnt) ? work.value : 8'd0;
    end
    word.out_byte_0 = lane_byte[0];
    word.out_byte_1 = lane_byte[1];
    word.out_byte_2 = lane_byte[2];
    word.out_byte_3 = lane_byte[3];
    word.byte_count = lane_cnt;
    // flags ride on the final word of a command only
    word.error_code = last ? work.err : brld_pkg::ERR_NONE;
    word.image_done = last && work.done;
    word.run_last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd_pop) begin
        work_valid <= 1'b1;
        work       <= cmd;
        left       <= cmd.count;
      end else if (emit && last) begin
        work_valid <= 1'b0;
      end else if (emit) begin
        left <= left - {5'd0, lane_cnt};
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_item  <= word;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
